>>> rtl/defq_pkg.sv
// shared types and codes for the debounced event queue
package defq_pkg;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_IGNORED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  localparam logic [7:0] WINDOW_RESET = 8'd8;

  typedef struct packed {
    logic [2:0]  src;
    logic        pressed;
    logic [31:0] stamp;
  } event_t;

  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

>>> rtl/debounced_event_fifo_unit.sv
// debounced event queue top level: per-input lockout and timestamped event ring
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | command, input_number, level_pressed, time_now
//  out_    | output    | out_valid / out_ready | status, event_*, drop_total
//  cfg_    | input     | cfg_valid / cfg_ready | debounce_window
//
// in each transaction the accept edge issues the reads of the
// timestamp memory and the event ring, then the update state updates both and
// loads the output register. a new transaction is taken while a result waits.
// a stalled output holds the update state until out_ready frees the register.
// reset clears pointers, drop count, timestamp valid bits and sets the window to 8.
module debounced_event_fifo_unit import defq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_INPUTS  = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [2:0]  in_input_number,
  input  logic        in_level_pressed,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_event_input,
  output logic        out_event_pressed,
  output logic [31:0] out_event_time,
  output logic [31:0] out_drop_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_debounce_window
);

  localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  window_r;
  logic [31:0] drop_cnt_r, drop_cnt_nxt;

  // accepted transaction
  logic             cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic             range_r;
  logic             level_r;
  logic [31:0]      time_r;
  logic [2:0]       src_r;

  // timestamp memory
  logic [31:0]           ts_mem [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] ts_vld_r;
  logic [31:0]           ts_rd_r;
  logic                  ts_rd_vld_r;
  logic                  ts_we;

  logic             in_fire, exec_go, out_free;
  logic [31:0]      num_wide;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic [31:0]      last_time, elapsed;
  logic             edge_ok;

  status_t    status_nxt;
  event_t     ev_nxt, ring_wr, ring_rd;
  ring_ctl_t  ring_ctl;
  ring_stat_t ring_stat;
  logic       push, pop, drop_inc;

  logic        out_valid_r;
  status_t     out_status_r;
  event_t      out_ev_r;
  logic [31:0] out_drop_r;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign num_wide = 32'(in_input_number);
  assign in_idx   = num_wide[IDX_W-1:0];
  assign in_range = (num_wide < 32'(NUM_INPUTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_debounce_window;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_command;
      idx_r   <= in_idx;
      range_r <= in_range;
      level_r <= in_level_pressed;
      time_r  <= in_time_now;
      src_r   <= in_input_number;
    end
  end

  always_ff @(posedge clk) begin
    if (ts_we) begin
      ts_mem[idx_r] <= time_r;
    end
    if (in_fire) begin
      ts_rd_r     <= ts_mem[in_idx];
      ts_rd_vld_r <= in_range ? ts_vld_r[in_idx] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_vld_r <= '0;
    end else if (ts_we) begin
      ts_vld_r[idx_r] <= 1'b1;
    end
  end

  // never-written timestamps read as zero
  assign last_time = ts_rd_vld_r ? ts_rd_r : '0;
  assign elapsed   = time_r - last_time;
  assign edge_ok   = range_r && (elapsed >= {24'd0, window_r});

  assign out_free = !out_valid_r || out_ready;
  assign exec_go  = (state_r == S_EXEC) && out_free;

  always_comb begin
    status_nxt = ST_EMPTY;
    ev_nxt     = '0;
    push       = 1'b0;
    pop        = 1'b0;
    ts_we      = 1'b0;
    drop_inc   = 1'b0;
    if (!cmd_r) begin
      if (!edge_ok) begin
        status_nxt = ST_IGNORED;
      end else begin
        ts_we = exec_go;
        if (ring_stat.full) begin
          drop_inc   = exec_go;
          status_nxt = ST_DROPPED;
        end else begin
          push       = exec_go;
          status_nxt = ST_QUEUED;
        end
      end
    end else if (!ring_stat.empty) begin
      pop        = exec_go;
      ev_nxt     = ring_rd;
      status_nxt = ST_POPPED;
    end
  end

  assign drop_cnt_nxt = drop_inc ? drop_cnt_r + 32'd1 : drop_cnt_r;

  assign ring_wr.src     = src_r;
  assign ring_wr.pressed = level_r;
  assign ring_wr.stamp   = time_r;

  assign ring_ctl.rd_en = in_fire;
  assign ring_ctl.push  = push;
  assign ring_ctl.pop   = pop;

  defq_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .wr_data (ring_wr),
    .rd_data (ring_rd),
    .stat    (ring_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      drop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      drop_cnt_r <= drop_cnt_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= status_nxt;
      out_ev_r     <= ev_nxt;
      out_drop_r   <= drop_cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_event_input   = out_ev_r.src;
  assign out_event_pressed = out_ev_r.pressed;
  assign out_event_time    = out_ev_r.stamp;
  assign out_drop_total    = out_drop_r;

  a_ring_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_stat.empty && ring_stat.full))
    else $error("ring reports empty and full together");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter update cycle");

  a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
    drop_inc |=> (drop_cnt_r == $past(drop_cnt_r) + 32'd1) && (out_status == ST_DROPPED))
    else $error("drop count or status wrong after a full ring");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && (out_status == ST_POPPED))
    else $error("pop did not produce a popped result");

endmodule

>>> rtl/defq_ring.sv
// event ring: synchronous event memory with read and write pointers
module defq_ring import defq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ring_ctl_t  ctl,
  input  event_t     wr_data,
  output event_t     rd_data,
  output ring_stat_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  event_t           mem [QUEUE_DEPTH];
  event_t           rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_inc, rd_inc;

  always_comb begin
    wr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    rd_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    wr_ptr_nxt = ctl.push ? wr_inc : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? rd_inc : rd_ptr_r;
  end

  // one slot stays free so full and empty differ
  assign stat.empty = (rd_ptr_r == wr_ptr_r);
  assign stat.full  = (wr_inc == rd_ptr_r);
  assign rd_data    = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule
